// ===== hw/rtl/acwb_pkg.sv =====
// ----------------------------------------------------------------------------
// acwb_pkg: shared definitions for the alarm clock with blink
// Widths, counter limits, register indexes, digit helpers and link structs.
// ----------------------------------------------------------------------------
`default_nettype none

package acwb_pkg;

    localparam int TICKS_PER_SECOND  = 1000;
    localparam int BLINK_TICKS       = 5000;
    localparam int BLINK_HALF_PERIOD = 200;

    localparam int MILLIS_W = 10;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 6;
    localparam int HOUR_W   = 5;
    localparam int REM_W    = 13;
    localparam int PHASE_W  = 8;
    localparam int KEY_W    = 8;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [MILLIS_W-1:0] MILLIS_LAST = MILLIS_W'(TICKS_PER_SECOND - 1);
    localparam logic [SEC_W-1:0]    SEC_LAST    = SEC_W'(59);
    localparam logic [MIN_W-1:0]    MIN_LAST    = MIN_W'(59);
    localparam logic [HOUR_W-1:0]   HOUR_LAST   = HOUR_W'(23);
    localparam logic [REM_W-1:0]    REM_START   = REM_W'(BLINK_TICKS);
    localparam logic [PHASE_W-1:0]  PHASE_LAST  = PHASE_W'(BLINK_HALF_PERIOD - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_SECOND = 2'd2;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } alarm_cfg_t;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
        logic       led_on;
        logic       alarm_active;
    } result_t;

    // Tens digit of a value below 60
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd50)      t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    // Ones digit, given the tens digit: v - 10*t
    function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [2:0] t);
        logic [5:0] r;
        r = v - {t, 3'b000} - {2'b00, t, 1'b0};
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/acwb_core.sv =====
// ----------------------------------------------------------------------------
// acwb_core: clock and blink state
// Holds the time and blink counters and computes one update per item.
// ----------------------------------------------------------------------------
`default_nettype none

module acwb_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           proc,
    input  wire logic                           tick,
    input  wire logic [acwb_pkg::KEY_W-1:0]     key_code,
    input  wire acwb_pkg::alarm_cfg_t           cfg,
    output acwb_pkg::result_t                   result
);

    logic [acwb_pkg::MILLIS_W-1:0] millis_reg, millis_next;
    logic [acwb_pkg::SEC_W-1:0]    sec_reg, sec_next;
    logic [acwb_pkg::MIN_W-1:0]    min_reg, min_next;
    logic [acwb_pkg::HOUR_W-1:0]   hour_reg, hour_next;
    logic [acwb_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [acwb_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic                          led_reg, led_next;
    logic [acwb_pkg::KEY_W-1:0]    prev_key_reg;
    logic [acwb_pkg::KEY_W-1:0]    pressed;
    logic [2:0]                    h_t, m_t, s_t;

    always_comb begin
        millis_next = millis_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        rem_next    = rem_reg;
        phase_next  = phase_reg;
        led_next    = led_reg;
        pressed     = key_code & ~prev_key_reg;

        // new key press ends a running window
        if (rem_reg != '0 && pressed != '0) begin
            rem_next = '0;
            led_next = 1'b0;
        end

        if (tick) begin
            if (millis_reg == acwb_pkg::MILLIS_LAST) begin
                millis_next = '0;
                if (sec_reg == acwb_pkg::SEC_LAST) begin
                    sec_next = '0;
                    if (min_reg == acwb_pkg::MIN_LAST) begin
                        min_next = '0;
                        hour_next = (hour_reg == acwb_pkg::HOUR_LAST) ? '0 : hour_reg + 1'b1;
                    end else begin
                        min_next = min_reg + 1'b1;
                    end
                end else begin
                    sec_next = sec_reg + 1'b1;
                end
            end else begin
                millis_next = millis_reg + 1'b1;
            end

            if (rem_next != '0) begin
                if (phase_reg == '0) led_next = ~led_next;
                phase_next = (phase_reg == acwb_pkg::PHASE_LAST) ? '0 : phase_reg + 1'b1;
                rem_next   = rem_next - 1'b1;
            end

            // restart the window on every tick at the alarm time
            if (hour_next == cfg.hour && min_next == cfg.minute && sec_next == cfg.second) begin
                rem_next   = acwb_pkg::REM_START;
                phase_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            millis_reg   <= '0;
            sec_reg      <= acwb_pkg::SEC_LAST;
            min_reg      <= acwb_pkg::MIN_LAST;
            hour_reg     <= acwb_pkg::HOUR_LAST;
            rem_reg      <= '0;
            phase_reg    <= '0;
            led_reg      <= 1'b0;
            prev_key_reg <= '0;
        end else if (proc) begin
            millis_reg   <= millis_next;
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            hour_reg     <= hour_next;
            rem_reg      <= rem_next;
            phase_reg    <= phase_next;
            led_reg      <= led_next;
            prev_key_reg <= key_code;
        end
    end

    always_comb begin
        h_t = acwb_pkg::tens_of({1'b0, hour_next});
        m_t = acwb_pkg::tens_of(min_next);
        s_t = acwb_pkg::tens_of(sec_next);
        result.hour_tens    = h_t[1:0];
        result.hour_ones    = acwb_pkg::ones_of({1'b0, hour_next}, h_t);
        result.minute_tens  = m_t;
        result.minute_ones  = acwb_pkg::ones_of(min_next, m_t);
        result.second_tens  = s_t;
        result.second_ones  = acwb_pkg::ones_of(sec_next, s_t);
        result.led_on       = led_next;
        result.alarm_active = (rem_next != '0);
    end

    a_millis_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && tick && millis_reg == acwb_pkg::MILLIS_LAST |=> millis_reg == '0)
        else $error("millisecond counter did not wrap");

    a_no_tick_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !tick |=> $stable(millis_reg) && $stable(sec_reg) && $stable(phase_reg))
        else $error("clock moved without a tick");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= acwb_pkg::PHASE_LAST)
        else $error("blink phase out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/alarm_clock_with_blink.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_with_blink: 24-hour clock with alarm blink window
// Input register, state update and result register; alarm time registers.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then its result is held
//   in the result register until the result side takes it.
// Throughput: 1 item per cycle while the result side takes every item.
// Reset (aresetn low, synchronous): clock at 23:59:59, window off, LED off,
//   alarm time 00:00:00, both stages empty.
`default_nettype none

module alarm_clock_with_blink (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [acwb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [acwb_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_tick,
    input  wire logic [7:0]                         s_key_code,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_hour_tens,
    output logic [3:0]                              m_hour_ones,
    output logic [2:0]                              m_minute_tens,
    output logic [3:0]                              m_minute_ones,
    output logic [2:0]                              m_second_tens,
    output logic [3:0]                              m_second_ones,
    output logic                                    m_led_on,
    output logic                                    m_alarm_active
);

    acwb_pkg::alarm_cfg_t cfg_reg;
    logic                 in_valid_reg;
    logic                 in_tick_reg;
    logic [7:0]           in_key_reg;
    logic                 out_valid_reg;
    acwb_pkg::result_t    out_reg;
    acwb_pkg::result_t    core_result;
    logic                 advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                acwb_pkg::CFG_ALARM_HOUR:   cfg_reg.hour   <= cfg_wdata[acwb_pkg::HOUR_W-1:0];
                acwb_pkg::CFG_ALARM_MINUTE: cfg_reg.minute <= cfg_wdata;
                acwb_pkg::CFG_ALARM_SECOND: cfg_reg.second <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_tick_reg <= s_tick;
            in_key_reg  <= s_key_code;
        end
        if (advance) out_reg <= core_result;
    end

    acwb_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .proc     (advance),
        .tick     (in_tick_reg),
        .key_code (in_key_reg),
        .cfg      (cfg_reg),
        .result   (core_result)
    );

    assign m_valid        = out_valid_reg;
    assign m_hour_tens    = out_reg.hour_tens;
    assign m_hour_ones    = out_reg.hour_ones;
    assign m_minute_tens  = out_reg.minute_tens;
    assign m_minute_ones  = out_reg.minute_ones;
    assign m_second_tens  = out_reg.second_tens;
    assign m_second_ones  = out_reg.second_ones;
    assign m_led_on       = out_reg.led_on;
    assign m_alarm_active = out_reg.alarm_active;

    a_stall_keeps_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped or changed while stalled");

    a_held_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_key_reg))
        else $error("pending item lost");

    a_led_off_after_press: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_tick_reg && core_result.alarm_active == 1'b0 && out_valid_reg
        && out_reg.alarm_active && m_ready |=> !out_reg.led_on)
        else $error("LED lit after window ended by key");

endmodule

`default_nettype wire

// ===== test/tb_alarm_clock_with_blink.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alarm_clock_with_blink: self-checking bench for the alarm clock
// Drives millisecond ticks and key codes through the valid/ready input. It
// tracks the clock, the blink window and the LED in its own model, and checks
// every displayed result field by field. It covers the midnight rollover, the
// matching alarm second and a window cut by a key.
// ----------------------------------------------------------------------------

module tb_alarm_clock_with_blink;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          MAX_REPORTS = 40;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [acwb_pkg::CFG_IDX_W-1:0]     cfg_index = acwb_pkg::CFG_ALARM_HOUR;
    logic [acwb_pkg::CFG_W-1:0]         cfg_wdata = '0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_tick = 1'b0;
    logic [7:0]                         s_key_code = 8'h00;
    logic                               m_valid;
    logic                               m_ready = 1'b1;
    logic [1:0]                         m_hour_tens;
    logic [3:0]                         m_hour_ones;
    logic [2:0]                         m_minute_tens;
    logic [3:0]                         m_minute_ones;
    logic [2:0]                         m_second_tens;
    logic [3:0]                         m_second_ones;
    logic                               m_led_on;
    logic                               m_alarm_active;

    // Clock model, starts at 23:59:59 like the block after reset
    logic [9:0]  ms_cnt     = '0;
    logic [5:0]  sec_cnt    = 6'd59;
    logic [5:0]  min_cnt    = 6'd59;
    logic [4:0]  hr_cnt     = 5'd23;
    logic [12:0] blink_left = '0;
    logic [7:0]  blink_ph   = '0;
    logic        led_lvl    = 1'b0;
    logic [7:0]  last_key   = 8'h00;
    logic [4:0]  alarm_hr   = '0;
    logic [5:0]  alarm_min  = '0;
    logic [5:0]  alarm_sec  = '0;

    acwb_pkg::result_t display_q[$];

    bit          full_rate = 1'b0;
    int          stall_left = 0;
    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          windows_opened = 0;
    int          windows_cut = 0;
    int unsigned cycle_count = 0;

    alarm_clock_with_blink i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tick         (s_tick),
        .s_key_code     (s_key_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hour_tens    (m_hour_tens),
        .m_hour_ones    (m_hour_ones),
        .m_minute_tens  (m_minute_tens),
        .m_minute_ones  (m_minute_ones),
        .m_second_tens  (m_second_tens),
        .m_second_ones  (m_second_ones),
        .m_led_on       (m_led_on),
        .m_alarm_active (m_alarm_active)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("alarm_clock_with_blink verification failed");
            $finish;
        end
    end

    // Advance the clock model by one accepted item and queue the display it yields
    task automatic predict_display(input logic tick, input logic [7:0] key);
        logic [7:0]        rising;
        acwb_pkg::result_t r;
        rising = key & ~last_key;
        if (blink_left != 0 && rising != 0) begin
            blink_left = '0;
            led_lvl = 1'b0;
            windows_cut++;
        end
        last_key = key;
        if (tick) begin
            if (int'(ms_cnt) + 1 < acwb_pkg::TICKS_PER_SECOND) begin
                ms_cnt++;
            end else begin
                ms_cnt = '0;
                if (sec_cnt != 6'd59) begin
                    sec_cnt++;
                end else begin
                    sec_cnt = '0;
                    if (min_cnt != 6'd59) begin
                        min_cnt++;
                    end else begin
                        min_cnt = '0;
                        hr_cnt = (hr_cnt == 5'd23) ? 5'd0 : hr_cnt + 5'd1;
                    end
                end
            end
            if (blink_left != 0) begin
                if (blink_ph == 0)
                    led_lvl = ~led_lvl;
                if (int'(blink_ph) + 1 >= acwb_pkg::BLINK_HALF_PERIOD)
                    blink_ph = '0;
                else
                    blink_ph++;
                blink_left--;
            end
            // restart the window, first toggle lands on the next tick
            if (hr_cnt == alarm_hr && min_cnt == alarm_min && sec_cnt == alarm_sec) begin
                if (blink_left == 0)
                    windows_opened++;
                blink_left = 13'(acwb_pkg::BLINK_TICKS);
                blink_ph = '0;
            end
        end
        r.hour_tens    = 2'(hr_cnt / 5'd10);
        r.hour_ones    = 4'(hr_cnt % 5'd10);
        r.minute_tens  = 3'(min_cnt / 6'd10);
        r.minute_ones  = 4'(min_cnt % 6'd10);
        r.second_tens  = 3'(sec_cnt / 6'd10);
        r.second_ones  = 4'(sec_cnt % 6'd10);
        r.led_on       = led_lvl;
        r.alarm_active = (blink_left != 0);
        display_q.push_back(r);
    endtask

    task automatic send_item(input logic tick, input logic [7:0] key);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_tick     <= tick;
        s_key_code <= key;
        do @(posedge aclk); while (!s_ready);
        predict_display(tick, key);
        items_sent++;
    endtask

    // Hold the input until every pending display has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (display_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_alarm(input logic [5:0] hour_val, input logic [5:0] min_val,
                             input logic [5:0] sec_val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= acwb_pkg::CFG_ALARM_HOUR;
        cfg_wdata <= hour_val;
        @(posedge aclk);
        cfg_index <= acwb_pkg::CFG_ALARM_MINUTE;
        cfg_wdata <= min_val;
        @(posedge aclk);
        cfg_index <= acwb_pkg::CFG_ALARM_SECOND;
        cfg_wdata <= sec_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        alarm_hr  = hour_val[4:0];
        alarm_min = min_val;
        alarm_sec = sec_val;
    endtask

    // press_odds out of 16: chance of a fresh random code with possible new presses
    function automatic logic [7:0] next_key(input int press_odds);
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < press_odds)
            return 8'($urandom);
        else if (pick < 12)
            return last_key;
        else if (pick < 15)
            return last_key & 8'($urandom);
        return 8'h00;
    endfunction

    function automatic logic mostly_tick();
        return ($urandom_range(0, 7) != 0);
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        acwb_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (display_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %0d%0d:%0d%0d:%0d%0d",
                             $time, m_hour_tens, m_hour_ones, m_minute_tens,
                             m_minute_ones, m_second_tens, m_second_ones);
            end else begin
                want = display_q.pop_front();
                check_field("hour_tens", want.hour_tens, m_hour_tens);
                check_field("hour_ones", want.hour_ones, m_hour_ones);
                check_field("minute_tens", want.minute_tens, m_minute_tens);
                check_field("minute_ones", want.minute_ones, m_minute_ones);
                check_field("second_tens", want.second_tens, m_second_tens);
                check_field("second_ones", want.second_ones, m_second_ones);
                check_field("led_on", want.led_on, m_led_on);
                check_field("alarm_active", want.alarm_active, m_alarm_active);
            end
            stall_left = full_rate ? 0 : $urandom_range(0, 6);
        end else if (stall_left != 0) begin
            stall_left--;
        end
        m_ready <= (stall_left == 0);
    end

    // Alarm fields out of range never match; keys with no window only update history
    task automatic test_alarm_out_of_range();
        set_alarm(6'h3F, 6'd59, 6'd59);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'h01);
        send_item(1'b1, 8'h80);
        send_item(1'b0, 8'hAA);
        send_item(1'b1, 8'h55);
        set_alarm(6'd23, 6'h3F, 6'd59);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'h0F);
        send_item(1'b0, 8'hF0);
        send_item(1'b1, 8'h00);
        set_alarm(6'd23, 6'd59, 6'h3F);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, 8'h7E);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'h81);
    endtask

    // Alarm on the reset time: the window restarts on every tick until midnight
    task automatic test_matching_second();
        int n;
        set_alarm(6'd23, 6'd59, 6'd59);
        n = 0;
        full_rate <= 1'b1;
        while (hr_cnt == 5'd23) begin
            if (n == 300)
                full_rate <= 1'b0;
            if (n == 500)
                drain_results();
            // no presses near the rollover so the window is live past midnight
            send_item(mostly_tick(), next_key(ms_cnt >= 10'd990 ? 0 : 3));
            n++;
        end
    endtask

    // Let the window blink past a half period, then end it with a new press
    task automatic test_window_key_cancel();
        repeat (240) send_item(mostly_tick(), next_key(0));
        while (blink_left != 0)
            send_item(mostly_tick(), next_key(2));
    endtask

    task automatic test_random_traffic();
        int n;
        set_alarm(6'd0, 6'd0, 6'd0);
        for (n = 0; n < 80; n++) begin
            full_rate <= (n >= 30 && n < 55);
            send_item(1'($urandom_range(0, 1)), 8'($urandom));
        end
        full_rate <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_alarm_out_of_range();
        test_matching_second();
        test_window_key_cancel();
        test_random_traffic();
        drain_results();
        $display("Sent %0d ticks and key codes across midnight, %0d displays checked",
                 items_sent, results_checked);
        $display("Blink windows opened: %0d, cut short by a key: %0d, mismatches: %0d",
                 windows_opened, windows_cut, error_count);
        if (error_count == 0 && display_q.size() == 0)
            $display("alarm_clock_with_blink verification clean");
        else
            $display("alarm_clock_with_blink verification failed");
        $finish;
    end

endmodule
